/* src/dq_pkg.sv */
// Shared constants, codes and interface types for the double-ended queue.
package dq_pkg;

  // Queue geometry
  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;

  // Request codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Memory access request from the controller
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // Registered result control from the controller
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       last;
    logic       from_ram;
  } res_ctl_t;

endpackage

/* src/dq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/dq_ctrl.sv */
// Queue controller: front index, entry count, request decode and list sequencer.
module dq_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [2:0]                cmd,
  input  logic [dq_pkg::DATA_W-1:0] value,
  output logic                      busy,
  output dq_pkg::mem_req_t          mem_req,
  output dq_pkg::res_ctl_t          res
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic                        state_r, state_nxt;
  logic [dq_pkg::IDX_W-1:0]    front_r, front_nxt;
  logic [dq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [dq_pkg::IDX_W-1:0]    rp_r, rp_nxt;
  logic [dq_pkg::IDX_W-1:0]    k_r, k_nxt;
  dq_pkg::res_ctl_t            res_r, res_nxt;

  logic [dq_pkg::SUM_W-1:0]    back_sum;
  logic [dq_pkg::IDX_W-1:0]    back_pos;
  logic [dq_pkg::IDX_W-1:0]    front_dec;
  logic                        is_full;
  logic                        is_empty;
  logic                        list_end;

  // Increment an index with wrap at the queue depth
  function automatic logic [dq_pkg::IDX_W-1:0] wrap_inc(input logic [dq_pkg::IDX_W-1:0] idx);
    logic [dq_pkg::IDX_W-1:0] r;
    if (idx == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + 1'b1;
    end
    return r;
  endfunction

  // Ring positions for pushes
  assign back_sum  = dq_pkg::SUM_W'(front_r) + dq_pkg::SUM_W'(count_r);
  assign back_pos  = (back_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                     ? dq_pkg::IDX_W'(back_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                     : dq_pkg::IDX_W'(back_sum);
  assign front_dec = (front_r == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : front_r - 1'b1;
  assign is_full   = (count_r == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty  = (count_r == '0);
  assign list_end  = (dq_pkg::CNT_W'(k_r) == count_r - 1'b1);

  assign busy = (state_r != S_IDLE);

  // Request decode and list sequencing
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    k_nxt         = k_r;
    res_nxt       = '0;
    mem_req       = '0;
    mem_req.wdata = value;
    mem_req.raddr = rp_r;
    if (state_r == S_IDLE) begin
      if (start) begin
        unique case (cmd)
          dq_pkg::CMD_PUSH_FRONT: begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
            if (is_full) begin
              res_nxt.status = dq_pkg::ST_FULL;
            end else begin
              res_nxt.status = dq_pkg::ST_OK;
              mem_req.we     = 1'b1;
              mem_req.waddr  = front_dec;
              front_nxt      = front_dec;
              count_nxt      = count_r + 1'b1;
            end
          end
          dq_pkg::CMD_PUSH_BACK: begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
            if (is_full) begin
              res_nxt.status = dq_pkg::ST_FULL;
            end else begin
              res_nxt.status = dq_pkg::ST_OK;
              mem_req.we     = 1'b1;
              mem_req.waddr  = back_pos;
              count_nxt      = count_r + 1'b1;
            end
          end
          dq_pkg::CMD_POP_FRONT: begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
            if (is_empty) begin
              res_nxt.status = dq_pkg::ST_EMPTY;
            end else begin
              res_nxt.status = dq_pkg::ST_OK;
              // popping the only entry leaves the front index in place
              if (count_r != dq_pkg::CNT_W'(1)) begin
                front_nxt = wrap_inc(front_r);
              end
              count_nxt = count_r - 1'b1;
            end
          end
          dq_pkg::CMD_POP_BACK: begin
            res_nxt.valid = 1'b1;
            res_nxt.last  = 1'b1;
            if (is_empty) begin
              res_nxt.status = dq_pkg::ST_EMPTY;
            end else begin
              res_nxt.status = dq_pkg::ST_OK;
              count_nxt      = count_r - 1'b1;
            end
          end
          dq_pkg::CMD_LIST: begin
            if (is_empty) begin
              res_nxt.valid  = 1'b1;
              res_nxt.last   = 1'b1;
              res_nxt.status = dq_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_LIST;
              rp_nxt    = front_r;
              k_nxt     = '0;
            end
          end
          default: begin
            // unused codes: no result, no state change
          end
        endcase
      end
    end else begin
      // one entry read per cycle; data returns with the result strobe
      mem_req.re       = 1'b1;
      res_nxt.valid    = 1'b1;
      res_nxt.status   = dq_pkg::ST_OK;
      res_nxt.from_ram = 1'b1;
      res_nxt.last     = list_end;
      rp_nxt           = wrap_inc(rp_r);
      k_nxt            = k_r + 1'b1;
      if (list_end) begin
        state_nxt = S_IDLE;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      res_r   <= res_nxt;
    end
  end

  // List walk pointers
  always_ff @(posedge clk) begin
    rp_r <= rp_nxt;
    k_r  <= k_nxt;
  end

  assign res = res_r;

endmodule

/* src/double_ended_queue.sv */
// Push/pop: result strobed the cycle after the transfer; busy stays low.
// List of N entries: busy while reading, one entry read per cycle from the entry RAM
// read port; one result per entry on consecutive cycles, via state and result registers.
// Results cannot be held off by the receiver; each is shown for exactly one cycle.
// Synchronous active-low reset empties the queue (front index and count to zero);
// entry RAM contents are not cleared and need no clearing pass.
module double_ended_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_cmd,
  input  logic signed [dq_pkg::DATA_W-1:0] in_value,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_item,
  output logic                             out_last
);

  dq_pkg::mem_req_t          mem_req;
  dq_pkg::res_ctl_t          res;
  logic [dq_pkg::DATA_W-1:0] rdata;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cmd     (in_cmd),
    .value   (in_value),
    .busy    (busy),
    .mem_req (mem_req),
    .res     (res)
  );

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // Result ports: entry value only on list results, zero otherwise
  assign out_valid  = res.valid;
  assign out_status = res.status;
  assign out_last   = res.last;
  assign out_item   = res.from_ram ? rdata : '0;

endmodule

/* test/double_ended_queue_tb.sv */
// Testbench for the double-ended queue: directed and random requests checked against a predictor.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT   = 200_000;
  localparam int          RANDOM_ITEMS  = 380;
  localparam int          DRAIN_CYCLES  = 8;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;

  // One expected result transfer
  typedef struct packed {
    logic [1:0]                status;
    logic [dq_pkg::DATA_W-1:0] item;
    logic                      last;
  } dq_result_t;

  logic                             clk      = 1'b0;
  logic                             rst_n    = 1'b0;
  logic                             start    = 1'b0;
  logic                             busy;
  logic [2:0]                       in_cmd   = dq_pkg::CMD_PUSH_FRONT;
  logic signed [dq_pkg::DATA_W-1:0] in_value = '0;
  logic                             out_valid;
  logic [1:0]                       out_status;
  logic signed [dq_pkg::DATA_W-1:0] out_item;
  logic                             out_last;

  // Predictor state: entry storage, front position and fill level
  logic [dq_pkg::DATA_W-1:0] entry_mem [dq_pkg::DEPTH];
  int                        front_pos;
  int                        fill_count;
  dq_result_t                awaited_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit steady         = 1'b0;

  double_ended_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_item   (out_item),
    .out_last   (out_last)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic add_result(input logic [1:0] status, input logic [dq_pkg::DATA_W-1:0] item,
                            input logic last);
    dq_result_t r;
    r.status = status;
    r.item   = item;
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  // Update the predicted queue for one accepted request and queue its results
  task automatic apply_request(input logic [2:0] cmd, input logic [dq_pkg::DATA_W-1:0] val);
    case (cmd)
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
        if (fill_count >= dq_pkg::DEPTH) begin
          add_result(dq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
            front_pos = (front_pos + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            entry_mem[front_pos] = val;
          end else begin
            entry_mem[(front_pos + fill_count) % dq_pkg::DEPTH] = val;
          end
          fill_count++;
          add_result(dq_pkg::ST_OK, '0, 1'b1);
        end
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK: begin
        if (fill_count == 0) begin
          add_result(dq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          // popping the only entry leaves the front position where it is
          if (cmd == dq_pkg::CMD_POP_FRONT && fill_count > 1)
            front_pos = (front_pos + 1) % dq_pkg::DEPTH;
          fill_count--;
          add_result(dq_pkg::ST_OK, '0, 1'b1);
        end
      end
      dq_pkg::CMD_LIST: begin
        if (fill_count == 0) begin
          add_result(dq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < fill_count; k++)
            add_result(dq_pkg::ST_OK, entry_mem[(front_pos + k) % dq_pkg::DEPTH],
                       k == fill_count - 1);
        end
      end
      default: ;  // unused codes are ignored
    endcase
  endtask

  // Result checker: sample mid-cycle, outputs change only at the rising edge
  always @(negedge clk) begin
    dq_result_t exp_r;
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid is unknown");
      end else if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d item=%0d last=%0b",
                                    out_status, out_item, out_last));
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_status !== exp_r.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, exp_r.status));
          if (out_item !== exp_r.item)
            report_mismatch($sformatf("item got %0d want %0d", out_item,
                                      $signed(exp_r.item)));
          if (out_last !== exp_r.last)
            report_mismatch($sformatf("last got %0b want %0b", out_last, exp_r.last));
        end
      end
    end
  end

  // Send one request with a random lead gap unless steady; start stays high for back-to-back transfers
  task automatic send_request(input logic [2:0] cmd, input logic [dq_pkg::DATA_W-1:0] val);
    int gap;
    bit taken;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd   <= cmd;
    in_value <= val;
    if (!start) start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    apply_request(cmd, val);
  endtask

  // Hold off the sender until every predicted result has been seen
  task automatic wait_drained();
    if (start) start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [dq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_BACK;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_BACK;
  endfunction

  // Pops and lists on a freshly reset queue
  task automatic test_empty_queue();
    send_request(dq_pkg::CMD_POP_FRONT, 32'h1234_5678);
    send_request(dq_pkg::CMD_POP_BACK, '1);
    send_request(dq_pkg::CMD_LIST, '0);
  endtask

  // Ordering at both ends with extreme values, and popping the only entry
  task automatic test_end_order();
    send_request(dq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(dq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(dq_pkg::CMD_PUSH_BACK, '1);
    send_request(dq_pkg::CMD_PUSH_FRONT, '0);
    send_request(dq_pkg::CMD_PUSH_BACK, 32'h5555_AAAA);
    send_request(dq_pkg::CMD_LIST, '0);
    send_request(dq_pkg::CMD_POP_FRONT, '0);
    send_request(dq_pkg::CMD_POP_BACK, '0);
    send_request(dq_pkg::CMD_LIST, '0);
    send_request(dq_pkg::CMD_POP_FRONT, '0);
    send_request(dq_pkg::CMD_POP_FRONT, '0);
    send_request(dq_pkg::CMD_LIST, '0);
    send_request(dq_pkg::CMD_POP_BACK, '0);
    send_request(dq_pkg::CMD_LIST, '0);
    send_request(dq_pkg::CMD_PUSH_FRONT, 32'hAAAA_5555);
    send_request(dq_pkg::CMD_LIST, '0);
  endtask

  // Unused request codes must produce nothing
  task automatic test_unused_codes();
    for (int c = 0; c < 3; c++) send_request(CMD_UNUSED_LO + 3'(c), pick_value());
    send_request(dq_pkg::CMD_LIST, '0);
  endtask

  // Fill to capacity, overflow at both ends, list everything, drain, then pop and list when empty
  task automatic test_full_queue();
    while (fill_count < dq_pkg::DEPTH) send_request(pick_push(), pick_value());
    send_request(dq_pkg::CMD_PUSH_FRONT, pick_value());
    send_request(dq_pkg::CMD_PUSH_BACK, pick_value());
    send_request(dq_pkg::CMD_LIST, '0);
    while (fill_count > 0) send_request(pick_pop(), pick_value());
    send_request(pick_pop(), '0);
    send_request(dq_pkg::CMD_LIST, '0);
  endtask

  // Random traffic that swings the fill level between empty and full
  task automatic test_random_traffic();
    int         sent;
    int         r;
    bit         grow;
    logic [2:0] cmd;
    sent = 0;
    grow = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 29) == 0) steady = !steady;
      if (fill_count == dq_pkg::DEPTH) grow = 1'b0;
      else if (fill_count == 0) grow = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow = !grow;
      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_UNUSED_LO + 3'($urandom_range(0, 2));
      else if (r < 13) cmd = dq_pkg::CMD_LIST;
      else if (r < (grow ? 68 : 38)) cmd = pick_push();
      else cmd = pick_pop();
      send_request(cmd, pick_value());
      if (cmd < CMD_UNUSED_LO) sent++;
    end
    steady = 1'b0;
  endtask

  initial begin
    front_pos  = 0;
    fill_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_end_order();
    test_unused_codes();
    test_full_queue();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dq_pkg.sv
src/dq_ram.sv
src/dq_ctrl.sv
src/double_ended_queue.sv
test/double_ended_queue_tb.sv
